/* rtl/core/scac_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// scac_pkg: shared types and CRC functions
// Reflected CRC-32 (poly 0xEDB88320) table, byte update, seed preload,
// register indexes and the request structs passed between the core stages.
// -----------------------------------------------------------------------------
package scac_pkg;

  localparam int MAX_CRC_BYTES = 4;
  localparam int LEN_W         = 3;
  localparam int IDX_W         = 2;

  typedef logic [31:0] crc_t;
  typedef crc_t crc_tab_t [256];

  localparam crc_t CRC_POLY = 32'hEDB88320;
  localparam crc_t CRC_INIT = 32'hFFFFFFFF;

  localparam logic [LEN_W-1:0] LEN_RESET = 3'd2;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CRC_BYTES);

  // configuration register indexes
  localparam logic REG_CRC_SEED   = 1'b0;
  localparam logic REG_CRC_LENGTH = 1'b1;

  // input opcodes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_GEN   = 1'b1;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_CRC     = 1'b1;

  typedef struct packed {
    crc_t             preload;
    logic [LEN_W-1:0] len;
  } cfg_t;

  typedef struct packed {
    logic             gen;
    logic [LEN_W-1:0] len;
    crc_t             fin;
    logic             pass;
  } summ_t;

  function automatic crc_t table_entry(logic [7:0] idx);
    crc_t v;
    v = {24'h000000, idx};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic crc_tab_t build_table();
    crc_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = table_entry(8'(i));
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = build_table();

  function automatic crc_t crc_update(crc_t crc, logic [7:0] b);
    return {8'h00, crc[31:8]} ^ CRC_TABLE[crc[7:0] ^ b];
  endfunction

  // absorb the four seed bytes, least significant first
  function automatic crc_t crc_preload(crc_t seed);
    crc_t c;
    c = CRC_INIT;
    for (int k = 0; k < 4; k++) begin
      c = crc_update(c, seed[8*k +: 8]);
    end
    return c;
  endfunction

  localparam crc_t PRELOAD_RESET = crc_preload(32'h00000000);

endpackage
`default_nettype wire

/* rtl/core/scac_cfg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// scac_cfg: configuration registers
// Holds the seed as its precomputed CRC preload and the saturated trailer
// length.
// -----------------------------------------------------------------------------
module scac_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  output scac_pkg::cfg_t cfg
);
  import scac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preload <= PRELOAD_RESET;
      cfg.len     <= LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CRC_SEED:   cfg.preload <= crc_preload(cfg_data);
        REG_CRC_LENGTH: cfg.len <= (cfg_data[LEN_W-1:0] > LEN_MAX) ? LEN_MAX
                                                                   : cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/scac_crc.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// scac_crc: per-byte CRC accumulate and trailer hold
// Absorbs one byte per unstalled cycle, holds back the check trailer, and at
// packet end registers a one-entry summary (final CRC, verdict) for the emitter.
// -----------------------------------------------------------------------------
module scac_crc (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            opcode,
  input  logic [7:0]      data_byte,
  input  logic            end_of_packet,
  input  scac_pkg::cfg_t  cfg,
  input  logic            summ_pop,
  output logic            summ_valid,
  output scac_pkg::summ_t summ
);
  import scac_pkg::*;

  typedef logic [MAX_CRC_BYTES-1:0][7:0] held_t;

  crc_t             crc_accum, crc_accum_next;
  held_t            held_bytes, held_next;
  logic [LEN_W-1:0] held_count, held_count_next;
  logic             in_packet;
  logic             pkt_gen;
  logic [LEN_W-1:0] pkt_len;
  logic             summ_valid_next;
  summ_t            summ_next;

  logic             accept;
  logic             start;
  crc_t             acc_base;
  logic [LEN_W-1:0] cnt_base;
  logic             gen_cur;
  logic [LEN_W-1:0] len_cur;
  logic             absorb;
  logic             fill;
  logic             shift;
  logic [7:0]       upd_byte;
  held_t            held_shift;
  logic             emit;

  // low len bytes of the CRC against the trailer, first held byte on top
  function automatic logic trailer_match(crc_t fin, held_t h, logic [LEN_W-1:0] len);
    logic ok;
    case (len)
      3'd1:    ok = (fin[7:0] == h[0]);
      3'd2:    ok = (fin[15:0] == {h[0], h[1]});
      3'd3:    ok = (fin[23:0] == {h[0], h[1], h[2]});
      3'd4:    ok = (fin == {h[0], h[1], h[2], h[3]});
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = summ_valid && !summ_pop;

  always_comb begin
    start    = !in_packet;
    acc_base = start ? cfg.preload : crc_accum;
    cnt_base = start ? '0 : held_count;
    gen_cur  = start ? (opcode == OP_GEN) : pkt_gen;
    len_cur  = start ? cfg.len : pkt_len;

    absorb = gen_cur || (len_cur == '0);
    fill   = !absorb && (cnt_base < len_cur);
    shift  = !absorb && !fill;

    // once the trailer window is full, the oldest held byte enters the CRC
    upd_byte       = absorb ? data_byte : held_bytes[0];
    crc_accum_next = (absorb || shift) ? crc_update(acc_base, upd_byte) : acc_base;

    held_shift = held_t'(held_bytes >> 8);
    for (int i = 0; i < MAX_CRC_BYTES; i++) begin
      held_next[i] = held_bytes[i];
      if (fill && (cnt_base == LEN_W'(i))) begin
        held_next[i] = data_byte;
      end else if (shift) begin
        if (LEN_W'(i + 1) < len_cur) begin
          held_next[i] = held_shift[i];
        end else if (LEN_W'(i + 1) == len_cur) begin
          held_next[i] = data_byte;
        end
      end
    end
    held_count_next = fill ? cnt_base + 1'b1 : cnt_base;

    summ_next.gen = gen_cur;
    summ_next.len = len_cur;
    summ_next.fin = ~crc_accum_next;
    if (gen_cur) begin
      summ_next.pass = 1'b0;
    end else if (len_cur == '0) begin
      summ_next.pass = 1'b1;
    end else if (held_count_next < len_cur) begin
      summ_next.pass = 1'b0;
    end else begin
      summ_next.pass = trailer_match(summ_next.fin, held_next, len_cur);
    end

    // generate with zero length yields nothing
    emit            = end_of_packet && !(gen_cur && (len_cur == '0));
    summ_valid_next = (summ_valid && !summ_pop) || (accept && emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      held_count <= '0;
      pkt_gen    <= 1'b0;
      pkt_len    <= '0;
      summ_valid <= 1'b0;
    end else begin
      summ_valid <= summ_valid_next;
      if (accept) begin
        in_packet  <= !end_of_packet;
        held_count <= held_count_next;
        pkt_gen    <= gen_cur;
        pkt_len    <= len_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc_accum  <= crc_accum_next;
      held_bytes <= held_next;
      if (end_of_packet) begin
        summ <= summ_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/scac_emit.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// scac_emit: result emitter
// Takes a packet summary and presents its results from registers: one
// verdict, or the low CRC bytes most significant first.
// -----------------------------------------------------------------------------
module scac_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            summ_valid,
  input  scac_pkg::summ_t summ,
  output logic            summ_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            kind,
  output logic [7:0]      crc_byte,
  output logic            pass,
  output logic            last
);
  import scac_pkg::*;

  logic             busy;
  summ_t            cur;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] sel_full;
  logic [IDX_W-1:0] sel;
  logic             load_ok;

  always_comb begin
    sel_full = cur.len - LEN_W'(1) - {1'b0, idx};
    sel      = sel_full[IDX_W-1:0];
    last     = cur.gen ? ({1'b0, idx} == (cur.len - LEN_W'(1))) : 1'b1;
    kind     = cur.gen ? KIND_CRC : KIND_VERDICT;
    crc_byte = cur.gen ? cur.fin[{sel, 3'b000} +: 8] : 8'h00;
    pass     = cur.gen ? 1'b0 : cur.pass;
  end

  assign out_valid = busy;
  assign load_ok   = !busy || (!out_stall && last);
  assign summ_pop  = summ_valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (summ_pop) begin
      busy <= 1'b1;
    end else if (busy && !out_stall && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (summ_pop) begin
      cur <= summ;
      idx <= '0;
    end else if (busy && !out_stall) begin
      idx <= idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/seeded_crc32_append_check_core.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// seeded_crc32_append_check_core: seeded CRC-32 append / check
// Byte stream in; per packet either the truncated CRC trailer bytes or a
// pass/fail verdict on the received trailer.
// -----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_stall, opcode, data_byte,    | one packet byte
//          | end_of_packet                             |
//  out     | out_valid, out_stall, kind, crc_byte,     | CRC byte or verdict
//          | pass, last                                |
//  cfg     | cfg_write, cfg_index, cfg_data            | seed / trailer length
//
//  One byte per cycle; the CRC update is one table lookup per byte.
//  A packet end queues one summary; it leaves as one verdict or as L CRC bytes,
//  one result per unstalled cycle, while the next packet's bytes keep coming.
//  Input stalls only while a summary waits and the emitter cannot take it.
//  A seed write takes effect from the next cycle. Reset clears control state.
// -----------------------------------------------------------------------------
module seeded_crc32_append_check_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  crc_byte,
  output logic        pass,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import scac_pkg::*;

  cfg_t  cfg;
  summ_t summ;
  logic  summ_valid;
  logic  summ_pop;

  scac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scac_crc u_crc (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .cfg           (cfg),
    .summ_pop      (summ_pop),
    .summ_valid    (summ_valid),
    .summ          (summ)
  );

  scac_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .summ_valid (summ_valid),
    .summ       (summ),
    .summ_pop   (summ_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .crc_byte   (crc_byte),
    .pass       (pass),
    .last       (last)
  );

endmodule
`default_nettype wire

/* rtl/core/scac_checker.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// scac_checker: port-level checks
// Watches the top-level ports for reset behavior, stall hold and the shape
// of each packet's result sequence.
// -----------------------------------------------------------------------------
module scac_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [7:0]  crc_byte,
  input logic        pass,
  input logic        last
);
  import scac_pkg::*;

  // leave reset with nothing pending on either side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("results or stall present right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(crc_byte)
                                  && $stable(pass) && $stable(last)))
    else $error("stalled result changed");

  // CRC bytes of one packet leave back to back
  a_crc_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (kind == KIND_CRC) && !last)
      |=> (out_valid && (kind == KIND_CRC)))
    else $error("CRC byte sequence broken");

  // a verdict is a single final result with no CRC byte
  a_verdict_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_VERDICT)) |-> (last && (crc_byte == 8'h00)))
    else $error("malformed verdict");

  // a generated byte never reports pass
  a_crc_no_pass: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_CRC)) |-> !pass)
    else $error("pass set on a CRC byte");

endmodule

bind seeded_crc32_append_check_core scac_checker u_checker (.*);
`default_nettype wire

/* tb/crc_result_checker.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// crc_result_checker: scoreboard for the seeded CRC-32 append / check core
// Watches the byte, result and register channels, runs a bit-serial CRC-32
// model of every packet and compares each result against the oldest one owed.
// The small package carries the bit-serial CRC so that the stimulus side can
// build valid trailers with the same arithmetic.
// -----------------------------------------------------------------------------
package crc32_bitwise_pkg;

  localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;

  // one byte through the reflected CRC, one bit per step
  function automatic logic [31:0] crc_shift_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ REFLECTED_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // all-ones start, then the seed bytes, least significant first
  function automatic logic [31:0] seeded_start(logic [31:0] seed);
    logic [31:0] c;
    c = 32'hFFFFFFFF;
    for (int k = 0; k < 4; k++) begin
      c = crc_shift_byte(c, seed[8*k +: 8]);
    end
    return c;
  endfunction

endpackage

module crc_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [7:0]  crc_byte,
  input  logic        pass,
  input  logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned owed_count
);
  import scac_pkg::*;
  import crc32_bitwise_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] crc_byte;
    logic       pass;
    logic       last;
  } crc_result_t;

  crc_result_t owed_results[$];

  logic [31:0] seed_reg;
  logic [2:0]  len_reg;
  logic [31:0] run_crc;
  logic [7:0]  trail [MAX_CRC_BYTES];
  int unsigned trail_cnt;
  int unsigned pkt_l;
  bit          busy;
  bit          pkt_gen;
  int unsigned fail_tally;

  initial begin
    fail_tally = 0;
  end

  // advance the packet model by one accepted byte; queue results at packet end
  task automatic absorb_byte(logic op, logic [7:0] b, logic eop);
    logic [31:0] fin;
    logic [31:0] trailer;
    logic [31:0] mask;
    bit          ok;
    crc_result_t r;
    if (!busy) begin
      run_crc   = seeded_start(seed_reg);
      trail_cnt = 0;
      pkt_gen   = (op == OP_GEN);
      pkt_l     = (len_reg > LEN_MAX) ? MAX_CRC_BYTES : int'(len_reg);
      busy      = 1'b1;
    end
    if (pkt_gen || pkt_l == 0) begin
      run_crc = crc_shift_byte(run_crc, b);
    end else if (trail_cnt < pkt_l) begin
      trail[trail_cnt] = b;
      trail_cnt++;
    end else begin
      // oldest held byte turns out to be payload
      run_crc = crc_shift_byte(run_crc, trail[0]);
      for (int i = 1; i < pkt_l; i++) trail[i-1] = trail[i];
      trail[pkt_l-1] = b;
    end
    if (eop) begin
      busy = 1'b0;
      fin  = ~run_crc;
      if (pkt_gen) begin
        for (int i = 0; i < pkt_l; i++) begin
          r.kind     = KIND_CRC;
          r.crc_byte = fin[8*(pkt_l-1-i) +: 8];
          r.pass     = 1'b0;
          r.last     = (i == pkt_l - 1);
          owed_results.push_back(r);
        end
      end else begin
        ok = 1'b1;
        if (pkt_l > 0) begin
          if (trail_cnt < pkt_l) begin
            ok = 1'b0;
          end else begin
            trailer = '0;
            mask    = '0;
            for (int i = 0; i < pkt_l; i++) begin
              trailer = {trailer[23:0], trail[i]};
              mask    = {mask[23:0], 8'hFF};
            end
            ok = ((fin & mask) == trailer);
          end
        end
        r.kind     = KIND_VERDICT;
        r.crc_byte = 8'h00;
        r.pass     = ok;
        r.last     = 1'b1;
        owed_results.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    crc_result_t exp_r;
    if (rst) begin
      seed_reg  = '0;
      len_reg   = LEN_RESET;
      busy      = 1'b0;
      pkt_gen   = 1'b0;
      pkt_l     = 0;
      trail_cnt = 0;
      run_crc   = seeded_start('0);
      foreach (trail[i]) trail[i] = 8'h00;
      owed_results.delete();
    end else begin
      // compare before queueing: a result never comes from this edge's byte
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing owed: kind %0d crc_byte %02h pass %0d last %0d",
                 kind, crc_byte, pass, last);
          fail_tally++;
        end else begin
          exp_r = owed_results.pop_front();
          if (kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, kind);
            fail_tally++;
          end
          if (crc_byte !== exp_r.crc_byte) begin
            $error("crc_byte: expected %02h, got %02h", exp_r.crc_byte, crc_byte);
            fail_tally++;
          end
          if (pass !== exp_r.pass) begin
            $error("pass: expected %0d, got %0d", exp_r.pass, pass);
            fail_tally++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, last);
            fail_tally++;
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_CRC_SEED) seed_reg = cfg_data;
        else len_reg = cfg_data[LEN_W-1:0];
      end
      if (in_valid && !in_stall) absorb_byte(opcode, data_byte, end_of_packet);
    end
    mismatches <= fail_tally;
    owed_count <= owed_results.size();
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// tb: top of the seeded CRC-32 append / check testbench
// Drives packet bytes and register writes into the core, with random idle
// bursts on the byte side and random stall bursts on the result side. A few
// directed packets cover edge lengths and seeds; random phases follow with
// mostly well-formed packets and some corrupted or truncated ones.
// -----------------------------------------------------------------------------
module tb;
  import scac_pkg::*;
  import crc32_bitwise_pkg::*;

  localparam int FLAW_NONE      = 0;
  localparam int FLAW_TRAILER   = 1;
  localparam int FLAW_SHORT     = 2;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  crc_byte;
  logic        pass;
  logic        last;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int unsigned mismatches;
  int unsigned owed_count;

  bit          quiet = 1'b0;
  int          sink_left = 0;
  int          idle_cycles = 0;
  logic [31:0] seed_now = '0;
  logic [2:0]  len_now = LEN_RESET;
  logic [7:0]  pkt_bytes[$];
  int          bytes_sent = 0;
  int          gen_pkts = 0;
  int          check_pkts = 0;
  int          settings_used = 1;

  seeded_crc32_append_check_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .crc_byte      (crc_byte),
    .pass          (pass),
    .last          (last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  crc_result_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .crc_byte      (crc_byte),
    .pass          (pass),
    .last          (last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .owed_count    (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: alternate stall bursts and open stretches
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      sink_left <= 0;
    end else if (sink_left > 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      sink_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
      sink_left <= $urandom_range(0, 11);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(logic op, logic [7:0] b, logic eop);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    data_byte     <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // later bytes carry a random opcode; the block must keep the first one
  task automatic send_packet(logic mode);
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte((i == 0) ? mode : logic'($urandom_range(0, 1)), pkt_bytes[i],
                i == pkt_bytes.size() - 1);
    end
    if (mode == OP_GEN) gen_pkts++;
    else check_pkts++;
  endtask

  task automatic fill_random(int n);
    repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // append the trailer for the payload held in pkt_bytes, then maybe spoil it
  task automatic append_trailer(int flaw);
    logic [31:0] c;
    int          l;
    int          pos;
    int          keep;
    l = (len_now > LEN_MAX) ? MAX_CRC_BYTES : int'(len_now);
    c = seeded_start(seed_now);
    foreach (pkt_bytes[i]) c = crc_shift_byte(c, pkt_bytes[i]);
    c = ~c;
    for (int i = l - 1; i >= 0; i--) pkt_bytes.push_back(c[8*i +: 8]);
    if (flaw == FLAW_TRAILER && l > 0) begin
      pos = $urandom_range(pkt_bytes.size() - l, pkt_bytes.size() - 1);
      pkt_bytes[pos] = pkt_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end else if (flaw == FLAW_SHORT && l > 1) begin
      keep = $urandom_range(1, l - 1);
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end
    if (pkt_bytes.size() == 0) fill_random(1);
  endtask

  // hold requests until every owed result is out and the core has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_CRC_SEED) seed_now = val;
    else len_now = val[LEN_W-1:0];
  endtask

  task automatic new_setting(logic [31:0] seed, logic [2:0] len);
    settle();
    write_reg(REG_CRC_SEED, seed);
    write_reg(REG_CRC_LENGTH, {29'd0, len});
    settings_used++;
  endtask

  task automatic random_phase(logic [31:0] seed, logic [2:0] len, int n_bytes);
    int start;
    int pick;
    new_setting(seed, len);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pkt_bytes.delete();
      pick = $urandom_range(0, 9);
      fill_random($urandom_range(0, 6));
      if (pick < 4) begin
        if (pkt_bytes.size() == 0) fill_random(1);
        send_packet(OP_GEN);
      end else begin
        if (pick < 8) append_trailer(FLAW_NONE);
        else if (pick == 8) append_trailer(FLAW_TRAILER);
        else append_trailer(FLAW_SHORT);
        send_packet(OP_CHECK);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_CHECK;
    data_byte     = 8'h00;
    end_of_packet = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = REG_CRC_SEED;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero seed, two trailer bytes
    pkt_bytes = '{8'h00};
    send_packet(OP_GEN);
    pkt_bytes = '{8'hFF};
    append_trailer(FLAW_NONE);
    send_packet(OP_CHECK);
    pkt_bytes = '{8'h5A};
    append_trailer(FLAW_TRAILER);
    send_packet(OP_CHECK);
    pkt_bytes = '{8'hA5};
    send_packet(OP_CHECK);
    pkt_bytes = '{8'h80};
    send_packet(OP_GEN);

    // zero length: generate stays silent, check always passes
    new_setting(32'hFFFFFFFF, 3'd0);
    pkt_bytes = '{8'hFF};
    send_packet(OP_GEN);
    pkt_bytes = '{8'h00, 8'hFF};
    send_packet(OP_CHECK);

    // length above range saturates to four bytes
    new_setting(32'h80000001, 3'd7);
    pkt_bytes = '{8'h12};
    send_packet(OP_GEN);
    pkt_bytes = '{8'h34};
    append_trailer(FLAW_NONE);
    send_packet(OP_CHECK);
    pkt_bytes.delete();
    append_trailer(FLAW_NONE);
    send_packet(OP_CHECK);
    pkt_bytes = '{8'h01, 8'h02, 8'h03};
    send_packet(OP_CHECK);

    random_phase($urandom, 3'($urandom_range(1, 4)), 40);
    random_phase(32'h00000000, 3'd4, 40);
    random_phase(32'hFFFFFFFF, 3'd1, 40);
    random_phase($urandom, 3'($urandom_range(0, 7)), 40);
    quiet <= 1'b1;
    random_phase($urandom, 3'd3, 40);
    settle();

    $display("Sent %0d bytes in %0d generate and %0d check packets over %0d settings,",
             bytes_sent, gen_pkts, check_pkts, settings_used);
    $display("including empty, short and corrupted trailers and mid-packet opcode flips.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
